[rtl/core/tgad_pkg.sv]
// Shared types and constants for the TGA true-color pixel decoder.
// No dependencies; imported by every module of the block.
package tgad_pkg;

	localparam int COORD_BITS = 16;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	localparam logic [4:0] HDR_ID_LEN = 5'd0;
	localparam logic [4:0] HDR_CMAP   = 5'd1;
	localparam logic [4:0] HDR_TYPE   = 5'd2;
	localparam logic [4:0] HDR_W_LO   = 5'd12;
	localparam logic [4:0] HDR_W_HI   = 5'd13;
	localparam logic [4:0] HDR_H_LO   = 5'd14;
	localparam logic [4:0] HDR_H_HI   = 5'd15;
	localparam logic [4:0] HDR_BPP    = 5'd16;
	localparam logic [4:0] HDR_DESCR  = 5'd17;

	localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
	localparam logic [7:0] CMAP_NONE      = 8'd0;
	localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;
	localparam logic [4:0] BPP_RGB        = 5'd3;
	localparam logic [4:0] BPP_RGBA       = 5'd4;
	localparam int         DESCR_MIRROR_X = 4;
	localparam int         DESCR_MIRROR_Y = 5;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_TYPE   = 2'd1;
	localparam logic [1:0] ST_FORMAT = 2'd2;

	typedef enum logic [2:0] {
		PH_HDR,
		PH_ID,
		PH_PIX,
		PH_TRAIL,
		PH_ERR
	} phase_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic        pixel_valid;
		logic [15:0] dest_x;
		logic [15:0] dest_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        image_done;
		logic [1:0]  status;
	} res_t;

	typedef struct packed {
		logic                  pixel_valid;
		logic                  image_done;
		logic [1:0]            status;
		logic                  mirror_x;
		logic                  mirror_y;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] width;
		logic [COORD_BITS-1:0] height;
		logic [7:0]            red;
		logic [7:0]            green;
		logic [7:0]            blue;
		logic [7:0]            alpha;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_ctl_t;

endpackage

[rtl/core/tgad_front.sv]
// Front end: header parser, identifier skip and pixel byte assembly.
// Emits one command per pixel or error into the command queue. Uses tgad_pkg.
module tgad_front
	import tgad_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   accept,
	input  in_t    data,
	output logic   cmd_push,
	output cmd_t   cmd
);

	phase_t                phase_q, phase_d;
	logic [4:0]            hcount_q, hcount_d;
	logic [7:0]            id_len_q, id_len_d;
	logic [7:0]            cmap_q, cmap_d;
	logic [7:0]            type_q, type_d;
	logic [4:0]            bpp_q, bpp_d;
	logic                  mir_x_q, mir_x_d;
	logic                  mir_y_q, mir_y_d;
	logic [15:0]           width_q, width_d;
	logic [15:0]           height_q, height_d;
	logic [7:0]            id_left_q, id_left_d;
	logic [1:0]            pbyte_q, pbyte_d;
	logic [7:0]            pbuf_q [4];
	logic [7:0]            pbuf_d [4];
	logic [7:0]            cur [4];
	logic [COORD_BITS-1:0] px_q, px_d;
	logic [COORD_BITS-1:0] py_q, py_d;
	logic [COORD_BITS-1:0] wm1, hm1;
	logic                  err_now;
	logic [1:0]            err_code;
	logic                  final_px;
	logic                  size_bad;
	logic [7:0]            b;
	logic                  last;

	assign b    = data.byte_in;
	assign last = data.last_byte;
	assign wm1  = COORD_BITS'(width_q - 16'd1);
	assign hm1  = COORD_BITS'(height_q - 16'd1);
	assign final_px = (px_q == wm1) && (py_q == hm1);
	assign size_bad = (width_q == 16'd0) || (height_q == 16'd0) ||
		((width_q >> COORD_BITS) != 16'd0) || ((height_q >> COORD_BITS) != 16'd0);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cur[i] = (pbyte_q == 2'(i)) ? b : pbuf_q[i];
		end
	end

	always_comb begin
		phase_d   = phase_q;
		hcount_d  = hcount_q;
		id_len_d  = id_len_q;
		cmap_d    = cmap_q;
		type_d    = type_q;
		bpp_d     = bpp_q;
		mir_x_d   = mir_x_q;
		mir_y_d   = mir_y_q;
		width_d   = width_q;
		height_d  = height_q;
		id_left_d = id_left_q;
		pbyte_d   = pbyte_q;
		pbuf_d    = pbuf_q;
		px_d      = px_q;
		py_d      = py_q;
		err_now   = 1'b0;
		err_code  = ST_OK;
		cmd_push  = 1'b0;
		cmd       = '0;
		if (accept) begin
			unique case (phase_q)
				PH_HDR: begin
					unique case (hcount_q)
						HDR_ID_LEN: id_len_d = b;
						HDR_CMAP:   cmap_d = b;
						HDR_TYPE:   type_d = b;
						HDR_W_LO:   width_d[7:0] = b;
						HDR_W_HI:   width_d[15:8] = b;
						HDR_H_LO:   height_d[7:0] = b;
						HDR_H_HI:   height_d[15:8] = b;
						HDR_BPP:    bpp_d = b[7:3];
						HDR_DESCR: begin
							mir_x_d = b[DESCR_MIRROR_X];
							mir_y_d = b[DESCR_MIRROR_Y];
						end
						default: ;
					endcase
					if (hcount_q != HDR_DESCR) begin
						hcount_d = hcount_q + 5'd1;
						if (last) begin
							err_now  = 1'b1;
							err_code = ST_TYPE;
						end
					end else begin
						hcount_d = '0;
						if (cmap_q != CMAP_NONE || type_q != TYPE_TRUECOLOR) begin
							err_now  = 1'b1;
							err_code = ST_TYPE;
						end else if (size_bad || (bpp_q != BPP_RGB && bpp_q != BPP_RGBA) ||
								last) begin
							err_now  = 1'b1;
							err_code = ST_FORMAT;
						end else begin
							px_d      = '0;
							py_d      = '0;
							pbyte_d   = '0;
							id_left_d = id_len_q;
							phase_d   = (id_len_q != 8'd0) ? PH_ID : PH_PIX;
						end
					end
				end
				PH_ID: begin
					if (last) begin
						err_now  = 1'b1;
						err_code = ST_FORMAT;
					end else begin
						id_left_d = id_left_q - 8'd1;
						if (id_left_q == 8'd1) begin
							phase_d = PH_PIX;
						end
					end
				end
				PH_PIX: begin
					pbuf_d[pbyte_q] = b;
					if (pbyte_q != ((bpp_q == BPP_RGBA) ? 2'd3 : 2'd2)) begin
						pbyte_d = pbyte_q + 2'd1;
						if (last) begin
							err_now  = 1'b1;
							err_code = ST_FORMAT;
						end
					end else begin
						pbyte_d = '0;
						if (last && !final_px) begin
							err_now  = 1'b1;
							err_code = ST_FORMAT;
						end else begin
							cmd_push        = 1'b1;
							cmd.pixel_valid = 1'b1;
							cmd.image_done  = final_px;
							cmd.status      = ST_OK;
							cmd.mirror_x    = mir_x_q;
							cmd.mirror_y    = mir_y_q;
							cmd.x           = px_q;
							cmd.y           = py_q;
							cmd.width       = COORD_BITS'(width_q);
							cmd.height      = COORD_BITS'(height_q);
							cmd.red         = cur[2];
							cmd.green       = cur[1];
							cmd.blue        = cur[0];
							cmd.alpha       = (bpp_q == BPP_RGBA) ? cur[3] : ALPHA_OPAQUE;
							if (final_px) begin
								phase_d  = last ? PH_HDR : PH_TRAIL;
								hcount_d = '0;
							end else if (px_q == wm1) begin
								px_d = '0;
								py_d = py_q + 1'b1;
							end else begin
								px_d = px_q + 1'b1;
							end
						end
					end
				end
				PH_TRAIL, PH_ERR: begin
					if (last) begin
						phase_d  = PH_HDR;
						hcount_d = '0;
					end
				end
				default: ;
			endcase
			if (err_now) begin
				cmd_push       = 1'b1;
				cmd            = '0;
				cmd.image_done = 1'b1;
				cmd.status     = err_code;
				phase_d        = last ? PH_HDR : PH_ERR;
				hcount_d       = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR;
			hcount_q  <= '0;
			id_len_q  <= '0;
			cmap_q    <= '0;
			type_q    <= '0;
			bpp_q     <= '0;
			mir_x_q   <= 1'b0;
			mir_y_q   <= 1'b0;
			width_q   <= '0;
			height_q  <= '0;
			id_left_q <= '0;
			pbyte_q   <= '0;
			px_q      <= '0;
			py_q      <= '0;
		end else begin
			phase_q   <= phase_d;
			hcount_q  <= hcount_d;
			id_len_q  <= id_len_d;
			cmap_q    <= cmap_d;
			type_q    <= type_d;
			bpp_q     <= bpp_d;
			mir_x_q   <= mir_x_d;
			mir_y_q   <= mir_y_d;
			width_q   <= width_d;
			height_q  <= height_d;
			id_left_q <= id_left_d;
			pbyte_q   <= pbyte_d;
			px_q      <= px_d;
			py_q      <= py_d;
		end
	end

	always_ff @(posedge clk) begin
		pbuf_q <= pbuf_d;
	end

endmodule

[rtl/core/tgad_cmdq.sv]
// Short command queue between front end and back end.
// Holds CMDQ_DEPTH commands of type cmd_t. Uses tgad_pkg.
module tgad_cmdq
	import tgad_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  q_ctl_t ctl_in,
	input  cmd_t   wr_data,
	input  logic   pop,
	output logic   full,
	output logic   valid,
	output cmd_t   rd_data
);

	cmd_t               mem [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_AW:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = ctl_in.push && !ctl_in.full;
	assign do_pop  = pop && valid;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (CMDQ_AW+1)'(CMDQ_DEPTH))
		else $error("command queue count overflow");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl_in.push && full))
		else $error("command pushed while queue full");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("command queue count did not advance");

endmodule

[rtl/core/tgad_back.sv]
// Back end: applies the origin mirror to each command and formats the result.
// Holds a two-entry result queue toward the consumer. Uses tgad_pkg.
module tgad_back
	import tgad_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic pop,
	output logic empty,
	output res_t result
);

	res_t       mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_pop;
	res_t       res;

	assign cmd_pop = cmd_valid && (cnt_q != 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_pop  = pop && !empty;
	assign result  = mem[rd_q];

	always_comb begin
		res             = '0;
		res.pixel_valid = cmd.pixel_valid;
		res.dest_x      = 16'(cmd.mirror_x ? cmd.width - cmd.x - 1'b1 : cmd.x);
		res.dest_y      = 16'(cmd.mirror_y ? cmd.height - cmd.y - 1'b1 : cmd.y);
		res.red         = cmd.red;
		res.green       = cmd.green;
		res.blue        = cmd.blue;
		res.alpha       = cmd.alpha;
		res.image_done  = cmd.image_done;
		res.status      = cmd.status;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			mem[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cmd_pop) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (cmd_pop && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !cmd_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

[rtl/core/tga_truecolor_pixel_decoder_core.sv]
// TGA uncompressed true-color pixel decoder, top level.
// Instantiates tgad_front, tgad_cmdq and tgad_back. Uses tgad_pkg.
//
// Input channel: one file byte per transaction (push/full). data.last_byte
// marks the final byte of a file; the next byte starts a new header.
// Result channel: queue-style (empty/pop). One result per completed pixel
// with its mirrored destination column and row, or one error result
// (pixel_valid 0, image_done 1, status nonzero). Header, identifier and
// trailing bytes produce no result.
// Throughput: one byte per cycle sustained while the command queue is not full,
// set by the front-end parser, which updates its counters once per byte.
// A result caused by an accepted byte is registered in the command queue,
// then in the result queue, before it is visible on the result ports.
// When the consumer stalls, the two-entry result queue and the four-entry
// command queue fill; full rises once the command queue is full.
// Reset (arst_n low) empties both queues and returns the parser to the
// start of a header.
module tga_truecolor_pixel_decoder_core
	import tgad_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  data,
	input  logic pop,
	output logic empty,
	output res_t result
);

	q_ctl_t qctl;
	logic   accept;
	logic   cmd_push;
	cmd_t   cmd_in;
	cmd_t   cmd_out;
	logic   cmd_valid;
	logic   cmd_pop;

	assign accept    = push && !full;
	assign qctl.push = cmd_push;
	assign qctl.full = full;

	tgad_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.data     (data),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	tgad_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (qctl),
		.wr_data (cmd_in),
		.pop     (cmd_pop),
		.full    (full),
		.valid   (cmd_valid),
		.rd_data (cmd_out)
	);

	tgad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

[dv/tga_truecolor_pixel_decoder_core_tb.sv]
// Testbench for tga_truecolor_pixel_decoder_core: streams TGA file bytes, predicts each
// pixel or error result in a scoreboard class and checks every popped result against it.
// Depends on tgad_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module tga_truecolor_pixel_decoder_core_tb;
	import tgad_pkg::*;

	class tgad_pixel_scoreboard;
		phase_t      ph;
		logic [4:0]  hdr_cnt;
		logic [7:0]  id_len, cmap, img_type, depth, descr, id_left;
		logic [15:0] wid, hgt, col, row;
		logic [1:0]  pix_byte;
		logic [7:0]  pix_buf [4];
		res_t        pixel_q [$];
		int          errors;

		function new();
			ph = PH_HDR;
			hdr_cnt = '0;
			id_len = '0; cmap = '0; img_type = '0; depth = '0; descr = '0; id_left = '0;
			wid = '0; hgt = '0; col = '0; row = '0;
			pix_byte = '0;
			foreach (pix_buf[i]) pix_buf[i] = '0;
			errors = 0;
		endfunction

		function int pending();
			return pixel_q.size();
		endfunction

		function void push_error(logic [1:0] code, logic lst);
			res_t r;
			r = '0;
			r.image_done = 1'b1;
			r.status = code;
			pixel_q.push_back(r);
			ph = lst ? PH_HDR : PH_ERR;
			hdr_cnt = '0;
		endfunction

		function void note_byte(in_t v);
			logic [7:0] b;
			logic       lst;
			logic       fin;
			int         bpp;
			res_t       r;
			b = v.byte_in;
			lst = v.last_byte;
			bpp = int'(depth >> 3);
			case (ph)
			PH_HDR: begin
				case (hdr_cnt)
				HDR_ID_LEN: id_len = b;
				HDR_CMAP:   cmap = b;
				HDR_TYPE:   img_type = b;
				HDR_W_LO:   wid = {8'd0, b};
				HDR_W_HI:   wid[15:8] = b;
				HDR_H_LO:   hgt = {8'd0, b};
				HDR_H_HI:   hgt[15:8] = b;
				HDR_BPP:    depth = b;
				HDR_DESCR:  descr = b;
				default: ;
				endcase
				if (hdr_cnt < HDR_DESCR) begin
					hdr_cnt = hdr_cnt + 5'd1;
					if (lst)
						push_error(ST_TYPE, 1'b1);
				end else begin
					hdr_cnt = '0;
					bpp = int'(depth >> 3);
					if (cmap != CMAP_NONE || img_type != TYPE_TRUECOLOR)
						push_error(ST_TYPE, lst);
					else if (wid == 0 || hgt == 0 || (bpp != BPP_RGB && bpp != BPP_RGBA))
						push_error(ST_FORMAT, lst);
					else if (lst)
						push_error(ST_FORMAT, 1'b1);
					else begin
						col = '0;
						row = '0;
						pix_byte = '0;
						id_left = id_len;
						ph = (id_len != 0) ? PH_ID : PH_PIX;
					end
				end
			end
			PH_ID: begin
				if (lst)
					push_error(ST_FORMAT, 1'b1);
				else begin
					id_left = id_left - 8'd1;
					if (id_left == 0)
						ph = PH_PIX;
				end
			end
			PH_PIX: begin
				pix_buf[pix_byte] = b;
				if (int'(pix_byte) + 1 < bpp) begin
					pix_byte = pix_byte + 2'd1;
					if (lst)
						push_error(ST_FORMAT, 1'b1);
				end else begin
					pix_byte = '0;
					fin = (col == wid - 16'd1) && (row == hgt - 16'd1);
					if (lst && !fin)
						push_error(ST_FORMAT, 1'b1);
					else begin
						r = '0;
						r.pixel_valid = 1'b1;
						r.dest_x = descr[DESCR_MIRROR_X] ? wid - col - 16'd1 : col;
						r.dest_y = descr[DESCR_MIRROR_Y] ? hgt - row - 16'd1 : row;
						r.red = pix_buf[2];
						r.green = pix_buf[1];
						r.blue = pix_buf[0];
						r.alpha = (bpp == BPP_RGBA) ? pix_buf[3] : ALPHA_OPAQUE;
						r.image_done = fin;
						r.status = ST_OK;
						pixel_q.push_back(r);
						if (fin) begin
							ph = lst ? PH_HDR : PH_TRAIL;
							hdr_cnt = '0;
						end else if ({1'b0, col} + 17'd1 >= {1'b0, wid}) begin
							col = '0;
							row = row + 16'd1;
						end else
							col = col + 16'd1;
					end
				end
			end
			default: begin
				if (lst) begin
					ph = PH_HDR;
					hdr_cnt = '0;
				end
			end
			endcase
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task cmp(string name, logic [15:0] got, logic [15:0] exp_val);
			if (got !== exp_val)
				report($sformatf("%s got %0h, expected %0h", name, got, exp_val));
		endtask

		task check_result(res_t got);
			res_t e;
			if (pixel_q.size() == 0)
				report($sformatf("result %h with nothing pending", got));
			else begin
				e = pixel_q.pop_front();
				cmp("pixel_valid", got.pixel_valid, e.pixel_valid);
				cmp("dest_x", got.dest_x, e.dest_x);
				cmp("dest_y", got.dest_y, e.dest_y);
				cmp("red", got.red, e.red);
				cmp("green", got.green, e.green);
				cmp("blue", got.blue, e.blue);
				cmp("alpha", got.alpha, e.alpha);
				cmp("image_done", got.image_done, e.image_done);
				cmp("status", got.status, e.status);
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	in_t  data = '0;
	logic full;
	logic empty;
	res_t result;

	tgad_pixel_scoreboard sb;
	in_t file_bytes [$];
	int  bytes_sent = 0;

	tga_truecolor_pixel_decoder_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.data   (data),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int draw_gap(int mode);
		case (mode)
		0: return 0;
		1: return $urandom_range(0, 2);
		default: return $urandom_range(0, 16);
		endcase
	endfunction

	function automatic void put_byte(logic [7:0] b);
		in_t v;
		v.byte_in = b;
		v.last_byte = 1'b0;
		file_bytes.push_back(v);
	endfunction

	function automatic void put_rand(int n);
		for (int i = 0; i < n; i++)
			put_byte(8'($urandom));
	endfunction

	function automatic void end_file();
		in_t v;
		v = file_bytes.pop_back();
		v.last_byte = 1'b1;
		file_bytes.push_back(v);
	endfunction

	function automatic void put_hdr(logic [7:0] idl, logic [7:0] cm, logic [7:0] typ,
			logic [15:0] w, logic [15:0] h, logic [7:0] dep, logic [7:0] dsc);
		put_byte(idl);
		put_byte(cm);
		put_byte(typ);
		put_rand(9);
		put_byte(w[7:0]);
		put_byte(w[15:8]);
		put_byte(h[7:0]);
		put_byte(h[15:8]);
		put_byte(dep);
		put_byte(dsc);
	endfunction

	function automatic void make_good();
		logic [7:0]  idl, dep;
		logic [15:0] w, h;
		int          trail;
		idl = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(4, 255)) : 8'($urandom_range(0, 3));
		w = 16'($urandom_range(1, 6));
		h = 16'($urandom_range(1, 4));
		dep = 8'($urandom_range(24, 39));
		trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		put_hdr(idl, CMAP_NONE, TYPE_TRUECOLOR, w, h, dep, 8'($urandom));
		put_rand(int'(idl) + int'(w) * int'(h) * int'(dep >> 3) + trail);
		end_file();
	endfunction

	function automatic void make_truncated();
		int cut;
		make_good();
		cut = $urandom_range(0, file_bytes.size() - 1);
		while (file_bytes.size() > cut + 1)
			void'(file_bytes.pop_back());
		end_file();
	endfunction

	function automatic void make_bad_header();
		logic [7:0]  cm, typ, dep;
		logic [15:0] w, h;
		cm = CMAP_NONE;
		typ = TYPE_TRUECOLOR;
		w = 16'($urandom);
		h = 16'($urandom);
		dep = 8'($urandom_range(24, 39));
		case ($urandom_range(0, 4))
		0: cm = 8'($urandom_range(1, 255));
		1: begin
			typ = 8'($urandom);
			if (typ == TYPE_TRUECOLOR)
				typ = 8'd3;
		end
		2: w = '0;
		3: h = '0;
		default: dep = $urandom_range(0, 1) ? 8'($urandom_range(0, 23)) : 8'($urandom_range(40, 255));
		endcase
		put_hdr(8'($urandom), cm, typ, w, h, dep, 8'($urandom));
		if ($urandom_range(0, 2) != 0)
			put_rand($urandom_range(1, 8));
		end_file();
	endfunction

	function automatic void make_noise();
		int n;
		in_t v;
		n = $urandom_range(1, 20);
		for (int i = 0; i < n; i++) begin
			v.byte_in = 8'($urandom);
			v.last_byte = ($urandom_range(0, 7) == 0);
			file_bytes.push_back(v);
		end
		end_file();
	endfunction

	task automatic send_file();
		in_t v;
		int  gap;
		int  mode;
		mode = $urandom_range(0, 2);
		while (file_bytes.size() != 0) begin
			v = file_bytes.pop_front();
			gap = draw_gap(mode);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			push <= 1'b1;
			data <= v;
			do @(posedge clk); while (full);
			sb.note_byte(v);
			bytes_sent++;
		end
	endtask

	task automatic run_directed();
		// 1x1 RGB, channel values 00, FF and 80
		put_hdr(8'd0, CMAP_NONE, TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd24, 8'h00);
		put_byte(8'h00); put_byte(8'hFF); put_byte(8'h80);
		end_file(); send_file();
		// 2x2 RGBA, both mirrors, id field, trailing bytes
		put_hdr(8'd2, CMAP_NONE, TYPE_TRUECOLOR, 16'd2, 16'd2, 8'd32, 8'h30);
		put_rand(2 + 16 + 2);
		end_file(); send_file();
		// 3x2 RGB, column mirror, last on final pixel
		put_hdr(8'd0, CMAP_NONE, TYPE_TRUECOLOR, 16'd3, 16'd2, 8'd24, 8'h10);
		put_rand(18);
		end_file(); send_file();
		// max dimensions, mirrored: one pixel, then cut short
		put_hdr(8'd0, CMAP_NONE, TYPE_TRUECOLOR, 16'hFFFF, 16'hFFFF, 8'd32, 8'hFF);
		put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF);
		put_byte(8'h00);
		end_file(); send_file();
		// color-mapped file, junk until last
		put_hdr(8'd0, 8'd1, TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd24, 8'h00);
		put_rand(3);
		end_file(); send_file();
		// wrong type, error byte is the last one
		put_hdr(8'd0, CMAP_NONE, 8'd10, 16'd1, 16'd1, 8'd24, 8'h00);
		end_file(); send_file();
		// zero width
		put_hdr(8'd0, CMAP_NONE, TYPE_TRUECOLOR, 16'd0, 16'd5, 8'd24, 8'h00);
		put_rand(2);
		end_file(); send_file();
		// 16-bit depth
		put_hdr(8'd0, CMAP_NONE, TYPE_TRUECOLOR, 16'd2, 16'd2, 8'd16, 8'h00);
		put_rand(1);
		end_file(); send_file();
		// short header
		put_rand(5);
		end_file(); send_file();
		// valid header ending the file
		put_hdr(8'd0, CMAP_NONE, TYPE_TRUECOLOR, 16'd2, 16'd1, 8'd24, 8'h00);
		end_file(); send_file();
		// cut inside the id field
		put_hdr(8'd5, CMAP_NONE, TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd24, 8'h00);
		put_rand(2);
		end_file(); send_file();
		// one-byte file
		put_rand(1);
		end_file(); send_file();
	endtask

	initial begin : stimulus
		int sel;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		while (bytes_sent < 2000) begin
			sel = $urandom_range(0, 99);
			if (sel < 65)
				make_good();
			else if (sel < 80)
				make_truncated();
			else if (sel < 92)
				make_bad_header();
			else
				make_noise();
			send_file();
		end
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : result_sink
		int gap;
		int mode;
		int n_pop;
		n_pop = 0;
		mode = 0;
		wait (arst_n);
		forever begin
			if (n_pop % 32 == 0)
				mode = $urandom_range(0, 2);
			gap = draw_gap(mode);
			// long hold-off: queues fill and full must push back
			if (n_pop == 10 || n_pop == 100 || n_pop == 250)
				gap = 1500;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_result(result);
			n_pop++;
		end
	end

	initial begin : watchdog
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
rtl/core/tgad_pkg.sv
rtl/core/tgad_front.sv
rtl/core/tgad_cmdq.sv
rtl/core/tgad_back.sv
rtl/core/tga_truecolor_pixel_decoder_core.sv
dv/tga_truecolor_pixel_decoder_core_tb.sv
